[src/assert_macros.svh]
// Assertion macros shared by the ray/triangle unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[src/rti_pkg.sv]
// Types and constants of the ray/triangle intersection unit.
package rti_pkg;

  localparam int CoordW   = 16;
  localparam int VertW    = 3 * CoordW;
  localparam int ThrW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = (VertW > ThrW) ? VertW : ThrW;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int NormW    = 2 * CoordW + 3;
  localparam int DenW     = 3 * CoordW + 5;
  localparam int NumW     = 3 * CoordW + 6;
  localparam int KFrac    = 16;
  localparam int QuoW     = CoordW + 19;
  localparam int KW       = QuoW + 1;

  // 2^(CoordW+17): clamp for the ray parameter magnitude
  localparam logic [QuoW-1:0] KLimit = {1'b0, 1'b1, {(QuoW - 2){1'b0}}};

  // operand order of the cross product terms
  localparam int CrossA [3] = '{1, 2, 0};
  localparam int CrossB [3] = '{2, 0, 1};

  typedef enum logic [CfgIdxW-1:0] {
    REG_VERTEX_A,
    REG_VERTEX_B,
    REG_VERTEX_C,
    REG_PAR_THR,
    REG_MIN_DIST
  } cfg_reg_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [NormW-1:0]  norm_t;

  localparam coord_t CoordMax = {1'b0, {(CoordW - 1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW - 1){1'b0}}};

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } ray_t;

  typedef struct packed {
    logic   hit;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } result_t;

  // x in the low bits
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vert_t;

  typedef struct packed {
    norm_t z;
    norm_t y;
    norm_t x;
  } normal_t;

  typedef struct packed {
    logic valid;
    logic miss;
    logic neg;
    ray_t ray;
  } div_tag_t;

endpackage

[src/ray_triangle_intersect_unit.sv]
// Top level of the ray/triangle intersection unit.
//
//  port group          dir  handshake              payload
//  start_i / busy_o    in   start_i && !busy_o     ray_i (rti_pkg::ray_t)
//  done_o              out  strobe, one cycle      result_o (rti_pkg::result_t)
//  cfg_valid_i/ready_o in   valid && ready         cfg_index_i, cfg_data_i
//
//  One ray enters per cycle; busy_o stays low.
//  Results come out in order, with no stall possible on either side; k comes
//  from a 35-stage divider, one quotient bit per stage.
//  rst_ni clears the valid bits and the registers (vertices 0, thresholds 1).
//  A new triangle applies to rays transferred from the cycle after its write.
`include "assert_macros.svh"
module ray_triangle_intersect_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  rti_pkg::ray_t                 ray_i,
  output logic                          done_o,
  output rti_pkg::result_t              result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rti_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rti_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rti_pkg::*;

  localparam int Latency = 13 + QuoW;

  logic [VertW-1:0]  va_q, vb_q, vc_q;
  logic [ThrW-1:0]   thr_q, min_dist_q;
  vert_t             vert_a, vert_b, vert_c;
  normal_t           normal;
  div_tag_t          front_tag, div_tag;
  logic [NumW-1:0]   num_mag;
  logic [DenW-1:0]   den_mag;
  logic signed [KW-1:0] k;
  logic              pl_valid, pl_miss;
  vert_t             point;
  logic              accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q       <= '0;
      vb_q       <= '0;
      vc_q       <= '0;
      thr_q      <= ThrW'(1);
      min_dist_q <= ThrW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_VERTEX_A: va_q       <= cfg_data_i[VertW-1:0];
        REG_VERTEX_B: vb_q       <= cfg_data_i[VertW-1:0];
        REG_VERTEX_C: vc_q       <= cfg_data_i[VertW-1:0];
        REG_PAR_THR:  thr_q      <= cfg_data_i[ThrW-1:0];
        REG_MIN_DIST: min_dist_q <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign vert_a = vert_t'(va_q);
  assign vert_b = vert_t'(vb_q);
  assign vert_c = vert_t'(vc_q);

  rti_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .ray_i      (ray_i),
    .vert_a_i   (vert_a),
    .vert_b_i   (vert_b),
    .vert_c_i   (vert_c),
    .par_thr_i  (thr_q),
    .normal_o   (normal),
    .tag_o      (front_tag),
    .num_mag_o  (num_mag),
    .den_mag_o  (den_mag)
  );

  rti_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (front_tag),
    .num_mag_i (num_mag),
    .den_mag_i (den_mag),
    .tag_o     (div_tag),
    .k_o       (k)
  );

  rti_place u_place (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (div_tag),
    .k_i        (k),
    .min_dist_i (min_dist_q),
    .valid_o    (pl_valid),
    .miss_o     (pl_miss),
    .point_o    (point)
  );

  rti_edge u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pl_valid),
    .miss_i   (pl_miss),
    .point_i  (point),
    .vert_a_i (vert_a),
    .vert_b_i (vert_b),
    .vert_c_i (vert_c),
    .normal_i (normal),
    .done_o   (done_o),
    .result_o (result_o)
  );

  `ASSERT_CLK(a_latency, accept |-> ##Latency done_o, "transferred ray gave no result in time")
  `ASSERT_CLK(a_done_src, done_o |-> $past(accept, Latency), "result without a transferred ray")
  `ASSERT_NEVER(a_busy_low, busy_o, "busy raised on a fully pipelined unit")

endmodule

[src/rti_front.sv]
// Front end: triangle normal, plane dot products and parallel test.
module rti_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  rti_pkg::ray_t               ray_i,
  input  rti_pkg::vert_t              vert_a_i,
  input  rti_pkg::vert_t              vert_b_i,
  input  rti_pkg::vert_t              vert_c_i,
  input  logic [rti_pkg::ThrW-1:0]    par_thr_i,
  output rti_pkg::normal_t            normal_o,
  output rti_pkg::div_tag_t           tag_o,
  output logic [rti_pkg::NumW-1:0]    num_mag_o,
  output logic [rti_pkg::DenW-1:0]    den_mag_o
);
  import rti_pkg::*;

  localparam int DpW = NormW + CoordW;
  localparam int NpW = NormW + DiffW;

  coord_t                  va [3], vb [3], vc [3];
  logic signed [DiffW-1:0] ac [3], bc [3], ao [3];
  logic signed [ProdW-1:0] cpa_q [3], cpb_q [3];
  norm_t                   n_q [3];

  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  ray_t                    ray1_q, ray2_q, ray3_q, ray4_q, ray5_q;
  coord_t                  org1 [3], dir2 [3];
  logic signed [DiffW-1:0] ao2_q [3];
  logic signed [DpW-1:0]   dp3_q [3];
  logic signed [NpW-1:0]   np3_q [3];
  logic signed [DenW-1:0]  den4_q;
  logic signed [NumW-1:0]  num4_q;
  logic [DenW-1:0]         den_mag;
  logic [NumW-1:0]         num_mag;
  logic [DenW-1:0]         den_mag_q;
  logic [NumW-1:0]         num_mag_q;
  logic                    miss5_q, neg5_q;

  assign va = '{vert_a_i.x, vert_a_i.y, vert_a_i.z};
  assign vb = '{vert_b_i.x, vert_b_i.y, vert_b_i.z};
  assign vc = '{vert_c_i.x, vert_c_i.y, vert_c_i.z};
  assign org1 = '{ray1_q.origin_x, ray1_q.origin_y, ray1_q.origin_z};
  assign dir2 = '{ray2_q.dir_x, ray2_q.dir_y, ray2_q.dir_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ac[i] = DiffW'(va[i]) - DiffW'(vc[i]);
      bc[i] = DiffW'(vb[i]) - DiffW'(vc[i]);
      ao[i] = DiffW'(va[i]) - DiffW'(org1[i]);
    end
  end

  // normal follows the vertex registers through the cpa_q/cpb_q and n_q registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      cpa_q[i] <= ProdW'(ac[CrossA[i]]) * ProdW'(bc[CrossB[i]]);
      cpb_q[i] <= ProdW'(ac[CrossB[i]]) * ProdW'(bc[CrossA[i]]);
      n_q[i]   <= NormW'(cpa_q[i]) - NormW'(cpb_q[i]);
    end
  end

  assign normal_o = '{z: n_q[2], y: n_q[1], x: n_q[0]};

  always_comb begin
    den_mag = den4_q[DenW-1] ? DenW'(-den4_q) : DenW'(den4_q);
    num_mag = num4_q[NumW-1] ? NumW'(-num4_q) : NumW'(num4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ray1_q <= ray_i;
    ray2_q <= ray1_q;
    ray3_q <= ray2_q;
    ray4_q <= ray3_q;
    ray5_q <= ray4_q;
    for (int i = 0; i < 3; i++) begin
      ao2_q[i] <= ao[i];
      dp3_q[i] <= DpW'(n_q[i]) * DpW'(dir2[i]);
      np3_q[i] <= NpW'(n_q[i]) * NpW'(ao2_q[i]);
    end
    den4_q    <= DenW'(dp3_q[0]) + DenW'(dp3_q[1]) + DenW'(dp3_q[2]);
    num4_q    <= NumW'(np3_q[0]) + NumW'(np3_q[1]) + NumW'(np3_q[2]);
    den_mag_q <= den_mag;
    num_mag_q <= num_mag;
    // zero denominator misses even with a zero threshold
    miss5_q   <= (den4_q == '0) || (den_mag < DenW'(par_thr_i));
    neg5_q    <= den4_q[DenW-1] ^ num4_q[NumW-1];
  end

  assign tag_o     = '{valid: v5_q, miss: miss5_q, neg: neg5_q, ray: ray5_q};
  assign num_mag_o = num_mag_q;
  assign den_mag_o = den_mag_q;

endmodule

[src/rti_div.sv]
// Pipelined restoring divider for the ray parameter k, one bit per stage.
`include "assert_macros.svh"
module rti_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rti_pkg::div_tag_t              tag_i,
  input  logic [rti_pkg::NumW-1:0]       num_mag_i,
  input  logic [rti_pkg::DenW-1:0]       den_mag_i,
  output rti_pkg::div_tag_t              tag_o,
  output logic signed [rti_pkg::KW-1:0]  k_o
);
  import rti_pkg::*;

  localparam int DivW = NumW + KFrac;
  localparam int HiW  = DivW - QuoW;
  localparam logic signed [KW-1:0] KMax = KW'(KLimit);

  logic [DivW-1:0] dvd;
  logic [HiW-1:0]  dvd_hi;

  div_tag_t        tag_q  [QuoW+1];
  logic            vld_q  [QuoW+1];
  logic [DenW-1:0] rem_q  [QuoW+1];
  logic [DenW-1:0] den_q  [QuoW+1];
  logic [QuoW-1:0] low_q  [QuoW+1];
  logic [QuoW-1:0] quo_q  [QuoW+1];
  logic            ovf_q  [QuoW+1];

  logic [DenW:0]   trial  [QuoW];
  logic            take   [QuoW];
  logic [DenW-1:0] rem_d  [QuoW];

  logic [QuoW-1:0]        quo_sat;
  logic signed [KW-1:0]   k_d;
  logic signed [KW-1:0]   k_q;
  div_tag_t               tag_f_q;
  logic                   vld_f_q;

  assign dvd    = {num_mag_i, {KFrac{1'b0}}};
  assign dvd_hi = dvd[DivW-1:QuoW];

  always_comb begin
    for (int j = 0; j < QuoW; j++) begin
      trial[j] = {rem_q[j], low_q[j][QuoW-1]};
      take[j]  = trial[j] >= {1'b0, den_q[j]};
      rem_d[j] = take[j] ? DenW'(trial[j] - {1'b0, den_q[j]}) : DenW'(trial[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= QuoW; j++) begin
        vld_q[j] <= 1'b0;
      end
      vld_f_q <= 1'b0;
    end else begin
      vld_q[0] <= tag_i.valid;
      for (int j = 0; j < QuoW; j++) begin
        vld_q[j+1] <= vld_q[j];
      end
      vld_f_q <= vld_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    // quotient of 2^QuoW or more saturates; the high part starts the remainder
    ovf_q[0] <= DenW'(dvd_hi) >= den_mag_i;
    rem_q[0] <= DenW'(dvd_hi);
    den_q[0] <= den_mag_i;
    low_q[0] <= dvd[QuoW-1:0];
    quo_q[0] <= '0;
    for (int j = 0; j < QuoW; j++) begin
      tag_q[j+1] <= tag_q[j];
      ovf_q[j+1] <= ovf_q[j];
      rem_q[j+1] <= rem_d[j];
      den_q[j+1] <= den_q[j];
      low_q[j+1] <= {low_q[j][QuoW-2:0], 1'b0};
      quo_q[j+1] <= {quo_q[j][QuoW-2:0], take[j]};
    end
    tag_f_q <= tag_q[QuoW];
    k_q     <= k_d;
  end

  always_comb begin
    quo_sat = (ovf_q[QuoW] || (quo_q[QuoW] > KLimit)) ? KLimit : quo_q[QuoW];
    k_d     = tag_q[QuoW].neg ? -$signed(KW'(quo_sat)) : $signed(KW'(quo_sat));
  end

  assign tag_o = '{valid: vld_f_q, miss: tag_f_q.miss, neg: tag_f_q.neg, ray: tag_f_q.ray};
  assign k_o   = k_q;

  `ASSERT_CLK(a_rem_init, (vld_q[0] && !tag_q[0].miss && !ovf_q[0]) |-> (rem_q[0] < den_q[0]), "divider start remainder not below divisor")
  `ASSERT_CLK(a_rem_last, (vld_q[QuoW] && !tag_q[QuoW].miss && !ovf_q[QuoW]) |-> (rem_q[QuoW] < den_q[QuoW]), "divider final remainder not below divisor")
  `ASSERT_CLK(a_k_bound, vld_f_q |-> ((k_q <= KMax) && (k_q >= -KMax)), "ray parameter outside its clamp")

endmodule

[src/rti_place.sv]
// Distance check and hit point O + R*k, saturated.
module rti_place (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rti_pkg::div_tag_t              tag_i,
  input  logic signed [rti_pkg::KW-1:0]  k_i,
  input  logic [rti_pkg::ThrW-1:0]       min_dist_i,
  output logic                           valid_o,
  output logic                           miss_o,
  output rti_pkg::vert_t                 point_o
);
  import rti_pkg::*;

  localparam int CmpW = ((KW > ThrW) ? KW : ThrW) + 1;
  localparam int PW   = CoordW + KW;
  localparam int StW  = PW - KFrac;
  localparam int SumW = ((StW > CoordW) ? StW : CoordW) + 1;

  logic signed [CmpW-1:0] k_ext, md_ext;
  logic                   v1_q, v2_q, v3_q;
  logic                   miss1_q, miss2_q, miss3_q;
  logic signed [KW-1:0]   k1_q;
  ray_t                   ray1_q;
  coord_t                 dir1 [3];
  coord_t                 org2_q [3];
  logic signed [PW-1:0]   prod2_q [3];
  logic signed [SumW-1:0] sum [3];
  coord_t                 pt_d [3];
  coord_t                 pt3_q [3];

  assign k_ext  = CmpW'(k_i);
  assign md_ext = $signed(CmpW'(min_dist_i));
  assign dir1   = '{ray1_q.dir_x, ray1_q.dir_y, ray1_q.dir_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // the arithmetic shift floors, also for negative steps
      sum[i] = SumW'(org2_q[i]) + SumW'($signed(prod2_q[i][PW-1:KFrac]));
      if (sum[i] > SumW'(CoordMax)) begin
        pt_d[i] = CoordMax;
      end else if (sum[i] < SumW'(CoordMin)) begin
        pt_d[i] = CoordMin;
      end else begin
        pt_d[i] = CoordW'(sum[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= tag_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    miss1_q <= tag_i.miss || (k_ext < md_ext);
    k1_q    <= k_i;
    ray1_q  <= tag_i.ray;
    miss2_q <= miss1_q;
    org2_q  <= '{ray1_q.origin_x, ray1_q.origin_y, ray1_q.origin_z};
    for (int i = 0; i < 3; i++) begin
      prod2_q[i] <= PW'(dir1[i]) * PW'(k1_q);
    end
    miss3_q <= miss2_q;
    pt3_q   <= pt_d;
  end

  assign valid_o = v3_q;
  assign miss_o  = miss3_q;
  assign point_o = '{z: pt3_q[2], y: pt3_q[1], x: pt3_q[0]};

endmodule

[src/rti_edge.sv]
// Edge same-side tests against the normal and result register.
module rti_edge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic                 miss_i,
  input  rti_pkg::vert_t       point_i,
  input  rti_pkg::vert_t       vert_a_i,
  input  rti_pkg::vert_t       vert_b_i,
  input  rti_pkg::vert_t       vert_c_i,
  input  rti_pkg::normal_t     normal_i,
  output logic                 done_o,
  output rti_pkg::result_t     result_o
);
  import rti_pkg::*;

  localparam int DotPW = 2 * NormW;
  localparam int DotSW = DotPW + 2;

  coord_t                  vtx [3][3];
  coord_t                  pt [3];
  norm_t                   nn [3];
  logic signed [DiffW-1:0] u [3][3], w [3][3];
  logic signed [ProdW-1:0] xa_q [3][3], xb_q [3][3];
  coord_t                  pt1_q [3];
  norm_t                   cr [3][3];
  logic signed [DotPW-1:0] dp2_q [3][3];
  coord_t                  pt2_q [3];
  logic signed [DotSW-1:0] dsum [3];
  logic                    in_tri;
  logic                    v1_q, v2_q, done_q;
  logic                    miss1_q, miss2_q;
  result_t                 res_q;

  assign vtx[0] = '{vert_a_i.x, vert_a_i.y, vert_a_i.z};
  assign vtx[1] = '{vert_b_i.x, vert_b_i.y, vert_b_i.z};
  assign vtx[2] = '{vert_c_i.x, vert_c_i.y, vert_c_i.z};
  assign pt     = '{point_i.x, point_i.y, point_i.z};
  assign nn     = '{normal_i.x, normal_i.y, normal_i.z};

  // edges AB, BC, CA
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int i = 0; i < 3; i++) begin
        u[e][i] = DiffW'(vtx[e][i]) - DiffW'(pt[i]);
        w[e][i] = DiffW'(vtx[CrossA[e]][i]) - DiffW'(pt[i]);
      end
    end
  end

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int i = 0; i < 3; i++) begin
        cr[e][i] = NormW'(xa_q[e][i]) - NormW'(xb_q[e][i]);
      end
    end
  end

  always_comb begin
    in_tri = 1'b1;
    for (int e = 0; e < 3; e++) begin
      dsum[e] = DotSW'(dp2_q[e][0]) + DotSW'(dp2_q[e][1]) + DotSW'(dp2_q[e][2]);
      in_tri  = in_tri & ~dsum[e][DotSW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 3; e++) begin
      for (int i = 0; i < 3; i++) begin
        xa_q[e][i]  <= ProdW'(u[e][CrossA[i]]) * ProdW'(w[e][CrossB[i]]);
        xb_q[e][i]  <= ProdW'(u[e][CrossB[i]]) * ProdW'(w[e][CrossA[i]]);
        dp2_q[e][i] <= DotPW'(cr[e][i]) * DotPW'(nn[i]);
      end
    end
    miss1_q <= miss_i;
    pt1_q   <= pt;
    miss2_q <= miss1_q;
    pt2_q   <= pt1_q;
    if (!miss2_q && in_tri) begin
      res_q <= '{hit: 1'b1, point_x: pt2_q[0], point_y: pt2_q[1], point_z: pt2_q[2]};
    end else begin
      res_q <= '0;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
